/* hw/rtl/mtp_pkg.sv */
// Shared types, codes and constants for the MIDI track event parser.
`default_nettype none
package mtp_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned WsumW  = 64;
  localparam int unsigned ProdW  = 56;
  localparam int unsigned TpqW   = 16;
  localparam int unsigned TempoW = 24;
  localparam int unsigned DivBitsPerStep = 4;
  localparam int unsigned DivSteps = WsumW / DivBitsPerStep;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [TpqW-1:0]   TPQ_RESET   = 16'd480;
  localparam logic [TempoW-1:0] TEMPO_RESET = 24'd1000000;
  localparam logic [TimeW-1:0]  TIME_MAX    = {TimeW{1'b1}};

  localparam logic [0:0] REG_TPQ   = 1'b0;
  localparam logic [0:0] REG_TEMPO = 1'b1;

  localparam logic [1:0] KIND_CHAN   = 2'd0;
  localparam logic [1:0] KIND_EOT    = 2'd1;
  localparam logic [1:0] KIND_BADTAG = 2'd2;

  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_SYSEX_CT = 8'hF7;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_TIMSIG = 8'h58;
  localparam logic [7:0] MASK_CLASS  = 8'hE0;
  localparam logic [7:0] CLASS_1DATA = 8'hC0;

  localparam logic [7:0] TAG_M = 8'h4D;
  localparam logic [7:0] TAG_T = 8'h54;
  localparam logic [7:0] TAG_R = 8'h72;
  localparam logic [7:0] TAG_K = 8'h6B;

  typedef enum logic [3:0] {
    PH_IDLE, PH_TAG, PH_TAGBAD, PH_LENSKIP, PH_DELTA, PH_STATUS, PH_METATYP,
    PH_DATA1, PH_DATA2, PH_LEN, PH_SKIP, PH_TEMPO
  } ph_t;

  typedef enum logic [2:0] {
    S_WAIT, S_MUL, S_ACC, S_DIV, S_PUT
  } seq_t;

  typedef struct packed {
    logic step;
    logic clr;
    logic mul;
    logic acc;
    logic div_load;
    logic div_run;
    logic put;
  } mtp_cmd_t;

  typedef struct packed {
    logic add;
    logic emit;
    logic div_last;
  } mtp_stat_t;

  function automatic logic [7:0] tag_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = TAG_M;
      2'd1: r = TAG_T;
      2'd2: r = TAG_R;
      default: r = TAG_K;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/mtp_if.sv */
// Channel interfaces: track bytes in, event items out, register writes.
`default_nettype none
interface mtp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] byte_in;
  modport source (output valid, output cmd, output byte_in, input ready);
  modport sink (input valid, input cmd, input byte_in, output ready);
endinterface

interface mtp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  status_byte;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic        has_second;
  logic [31:0] tick_total;
  logic [47:0] time_us;
  modport source (output valid, output kind, output status_byte, output first_data,
                  output second_data, output has_second, output tick_total,
                  output time_us, input ready);
  modport sink (input valid, input kind, input status_byte, input first_data,
                input second_data, input has_second, input tick_total,
                input time_us, output ready);
endinterface

interface mtp_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/midi_track_event_parser.sv */
// Top level of the MIDI track event parser.
//
//  channel  dir  payload                                         accepted when
//  in_ch    in   cmd, byte_in                                    valid && ready
//  out_ch   out  kind, status_byte, first/second_data, has_second,
//                tick_total, time_us                              valid && ready
//  cfg_ch   in   index (0 ticks_per_quarter, 1 initial_tempo), data  valid && ready
//
// A byte that produces nothing takes only the step; a delta time end takes step,
// multiply and accumulate. A byte that completes an event takes the step, the run of
// the 4-bit-per-cycle divider, then hand-off into the output register.
// Reset is synchronous; no clearing pass. A full output register lets bytes in
// until the next result is ready; that result then holds byte intake until the
// register drains. Config writes are taken every cycle.
`default_nettype none
module midi_track_event_parser
  import mtp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  mtp_in_if.sink    in_ch,
  mtp_out_if.source out_ch,
  mtp_cfg_if.sink   cfg_ch
);

  mtp_cmd_t          cmd;
  mtp_stat_t         stat, pstat;
  logic              div_last;
  logic [31:0]       delta_hold;
  logic [TempoW-1:0] tempo_now;
  logic [1:0]        res_kind;
  logic [7:0]        res_status, res_d0, res_d1;
  logic              res_two, res_stamp;
  logic [31:0]       res_tick;
  logic [TimeW-1:0]  quot_sat;
  logic              out_full, out_take, cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;
  assign out_take     = out_ch.valid && out_ch.ready;
  assign out_full     = out_ch.valid;
  assign stat         = '{add: pstat.add, emit: pstat.emit, div_last: div_last};

  mtp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .out_full (out_full),
    .out_take (out_take),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_cmd      (in_ch.cmd),
    .b           (in_ch.byte_in),
    .tempo_wr    (cfg_fire && cfg_ch.index == REG_TEMPO),
    .tempo_wdata (cfg_ch.data),
    .stat        (pstat),
    .delta_hold  (delta_hold),
    .tempo_now   (tempo_now),
    .res_kind    (res_kind),
    .res_status  (res_status),
    .res_d0      (res_d0),
    .res_d1      (res_d1),
    .res_two     (res_two),
    .res_tick    (res_tick),
    .res_stamp   (res_stamp)
  );

  mtp_time u_time (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .tpq_wr     (cfg_fire && cfg_ch.index == REG_TPQ),
    .tpq_wdata  (cfg_ch.data[TpqW-1:0]),
    .delta_hold (delta_hold),
    .tempo_now  (tempo_now),
    .div_last   (div_last),
    .quot_sat   (quot_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.put) begin
      out_ch.valid <= 1'b1;
    end else if (out_take) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      out_ch.kind        <= res_kind;
      out_ch.status_byte <= res_status;
      out_ch.first_data  <= res_d0;
      out_ch.second_data <= res_d1;
      out_ch.has_second  <= res_two;
      out_ch.tick_total  <= res_tick;
      out_ch.time_us     <= res_stamp ? quot_sat : '0;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mtp_ctrl.sv */
// Sequencer: byte step, multiply, accumulate, divide and result hand-off.
`default_nettype none
module mtp_ctrl
  import mtp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_cmd,
  output logic           in_ready,
  input  wire logic      out_full,
  input  wire logic      out_take,
  input  wire mtp_stat_t stat,
  output mtp_cmd_t       cmd
);

  seq_t st, st_next;
  logic fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_WAIT;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next  = st;
    in_ready = (st == S_WAIT);
    fire     = in_valid && in_ready;
    cmd      = '0;
    case (st)
      S_WAIT: begin
        cmd.step = fire;
        cmd.clr  = fire && in_cmd;
        if (fire && stat.add) begin
          st_next = S_MUL;
        end else if (fire && stat.emit) begin
          cmd.div_load = 1'b1;
          st_next      = S_DIV;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        st_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        st_next = S_WAIT;
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (stat.div_last) st_next = S_PUT;
      end
      S_PUT: begin
        // hold until the output register is free
        if (!out_full || out_take) begin
          cmd.put = 1'b1;
          st_next = S_WAIT;
        end
      end
      default: st_next = S_WAIT;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/mtp_parse.sv */
// Byte parser: chunk header, delta times, running status, meta and sysex.
`default_nettype none
module mtp_parse
  import mtp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mtp_cmd_t          cmd,
  input  wire logic              in_cmd,
  input  wire logic [7:0]        b,
  input  wire logic              tempo_wr,
  input  wire logic [TempoW-1:0] tempo_wdata,
  output mtp_stat_t              stat,
  output logic [31:0]            delta_hold,
  output logic [TempoW-1:0]      tempo_now,
  output logic [1:0]             res_kind,
  output logic [7:0]             res_status,
  output logic [7:0]             res_d0,
  output logic [7:0]             res_d1,
  output logic                   res_two,
  output logic [31:0]            res_tick,
  output logic                   res_stamp
);

  ph_t         phase, phase_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [31:0] varlen_acc, varlen_acc_next;
  logic [31:0] skip_left, skip_left_next;
  logic [7:0]  running_type, running_type_next;
  logic [7:0]  held_data, held_data_next;
  logic [15:0] tempo_build, tempo_build_next;
  logic [TempoW-1:0] tempo_now_next;
  logic [31:0] tick_sum, tick_sum_next;

  logic [31:0] vl_new;
  logic [32:0] tick_add;
  logic        disp, chan, emit, stamp, two;
  logic [7:0]  disp_rt, disp_d0, chan_d0, e_st, e_d0, e_d1;
  logic [1:0]  e_kind;
  logic [2:0]  bc_inc;

  assign vl_new   = {varlen_acc[24:0], b[6:0]};
  assign tick_add = {1'b0, tick_sum} + {1'b0, vl_new};
  assign bc_inc   = byte_count + 3'd1;

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    varlen_acc_next   = varlen_acc;
    skip_left_next    = skip_left;
    running_type_next = running_type;
    held_data_next    = held_data;
    tempo_build_next  = tempo_build;
    tempo_now_next    = tempo_now;
    tick_sum_next     = tick_sum;
    stat              = '0;
    disp = 1'b0; disp_rt = running_type; disp_d0 = b;
    chan = 1'b0; chan_d0 = b;
    emit = 1'b0; stamp = 1'b0; two = 1'b0;
    e_kind = KIND_CHAN; e_st = '0; e_d0 = '0; e_d1 = '0;

    if (in_cmd) begin
      phase_next        = PH_TAG;
      byte_count_next   = '0;
      varlen_acc_next   = '0;
      skip_left_next    = '0;
      running_type_next = '0;
      held_data_next    = '0;
      tempo_build_next  = '0;
      tick_sum_next     = '0;
    end else begin
      case (phase)
        PH_TAG, PH_TAGBAD: begin
          if (b != tag_byte(byte_count[1:0])) phase_next = PH_TAGBAD;
          byte_count_next = bc_inc;
          if (bc_inc[2]) begin
            byte_count_next = '0;
            if (phase_next == PH_TAGBAD) begin
              phase_next = PH_IDLE;
              emit       = 1'b1;
              e_kind     = KIND_BADTAG;
            end else begin
              phase_next = PH_LENSKIP;
            end
          end
        end
        PH_LENSKIP: begin
          byte_count_next = bc_inc;
          if (bc_inc[2]) begin
            byte_count_next = '0;
            varlen_acc_next = '0;
            phase_next      = PH_DELTA;
          end
        end
        PH_DELTA: begin
          varlen_acc_next = vl_new;
          if (!b[7]) begin
            stat.add        = 1'b1;
            tick_sum_next   = tick_add[32] ? 32'hFFFF_FFFF : tick_add[31:0];
            varlen_acc_next = '0;
            phase_next      = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b[7]) begin
            if (b == ST_META) begin
              phase_next = PH_METATYP;
            end else begin
              running_type_next = b;
              if (b == ST_SYSEX || b == ST_SYSEX_CT) begin
                varlen_acc_next = '0;
                phase_next      = PH_LEN;
              end else begin
                phase_next = PH_DATA1;
              end
            end
          end else begin
            disp = 1'b1;
          end
        end
        PH_METATYP: begin
          running_type_next = b;
          disp    = 1'b1;
          disp_rt = b;
          disp_d0 = ST_META;
        end
        PH_DATA1: chan = 1'b1;
        PH_DATA2: begin
          emit            = 1'b1;
          stamp           = 1'b1;
          two             = 1'b1;
          e_st            = running_type;
          e_d0            = held_data;
          e_d1            = b;
          varlen_acc_next = '0;
          phase_next      = PH_DELTA;
        end
        PH_LEN: begin
          varlen_acc_next = vl_new;
          if (!b[7]) begin
            varlen_acc_next = '0;
            if (running_type == META_EOT) begin
              phase_next = PH_IDLE;
              emit       = 1'b1;
              stamp      = 1'b1;
              e_kind     = KIND_EOT;
              e_st       = META_EOT;
            end else if (running_type == META_TEMPO) begin
              byte_count_next  = '0;
              tempo_build_next = '0;
              phase_next       = PH_TEMPO;
            end else begin
              skip_left_next = (running_type == META_TIMSIG) ? 32'd4 : vl_new;
              phase_next     = (skip_left_next != '0) ? PH_SKIP : PH_DELTA;
            end
          end
        end
        PH_SKIP: begin
          if (skip_left != '0) skip_left_next = skip_left - 32'd1;
          if (skip_left_next == '0) begin
            varlen_acc_next = '0;
            phase_next      = PH_DELTA;
          end
        end
        PH_TEMPO: begin
          if (byte_count < 3'd2) begin
            tempo_build_next = {tempo_build[7:0], b};
            byte_count_next  = bc_inc;
          end else begin
            tempo_now_next  = {tempo_build, b};
            byte_count_next = '0;
            varlen_acc_next = '0;
            phase_next      = PH_DELTA;
          end
        end
        default: ;
      endcase

      // meta types below 80h, sysex types (and a cleared running type) take a length next
      if (disp) begin
        if (disp_rt < 8'h80 || disp_rt == ST_SYSEX || disp_rt == ST_SYSEX_CT) begin
          varlen_acc_next = '0;
          phase_next      = PH_LEN;
        end else begin
          chan    = 1'b1;
          chan_d0 = disp_d0;
        end
      end
      if (chan) begin
        if ((running_type_next & MASK_CLASS) != CLASS_1DATA) begin
          held_data_next = chan_d0;
          phase_next     = PH_DATA2;
        end else begin
          emit            = 1'b1;
          stamp           = 1'b1;
          e_st            = running_type_next;
          e_d0            = chan_d0;
          varlen_acc_next = '0;
          phase_next      = PH_DELTA;
        end
      end
    end
    stat.emit = emit;
    if (tempo_wr) tempo_now_next = tempo_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_count   <= '0;
      varlen_acc   <= '0;
      skip_left    <= '0;
      running_type <= '0;
      held_data    <= '0;
      tempo_build  <= '0;
      tempo_now    <= TEMPO_RESET;
      tick_sum     <= '0;
    end else if (cmd.step) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      varlen_acc   <= varlen_acc_next;
      skip_left    <= skip_left_next;
      running_type <= running_type_next;
      held_data    <= held_data_next;
      tempo_build  <= tempo_build_next;
      tempo_now    <= tempo_now_next;
      tick_sum     <= tick_sum_next;
    end else if (tempo_wr) begin
      tempo_now <= tempo_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && stat.add) delta_hold <= vl_new;
    if (cmd.step && emit) begin
      res_kind   <= e_kind;
      res_status <= e_st;
      res_d0     <= e_d0;
      res_d1     <= e_d1;
      res_two    <= two && ((e_st & MASK_CLASS) != CLASS_1DATA);
      res_tick   <= stamp ? tick_sum : '0;
      res_stamp  <= stamp;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mtp_time.sv */
// Time stamp path: delta times tempo, saturating sum, 4-bit-a-cycle divider.
`default_nettype none
module mtp_time
  import mtp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mtp_cmd_t          cmd,
  input  wire logic              tpq_wr,
  input  wire logic [TpqW-1:0]   tpq_wdata,
  input  wire logic [31:0]       delta_hold,
  input  wire logic [TempoW-1:0] tempo_now,
  output logic                   div_last,
  output logic [TimeW-1:0]       quot_sat
);

  logic [TpqW-1:0]    tpq;
  logic [ProdW-1:0]   prod;
  logic [WsumW-1:0]   wsum;
  logic [WsumW-1:0]   dvd, dvd_next;
  logic [TpqW-1:0]    rem, rem_next;
  logic [DivCntW-1:0] cnt;
  logic [TpqW-1:0]    dsr;
  logic [WsumW:0]     wsum_add;
  logic [TpqW:0]      trial;

  assign dsr      = (tpq == '0) ? TpqW'(1) : tpq;
  assign wsum_add = {1'b0, wsum} + {{(WsumW + 1 - ProdW){1'b0}}, prod};
  assign div_last = (cnt == DivCntW'(DivSteps - 1));
  assign quot_sat = (dvd[WsumW-1:TimeW] != '0) ? TIME_MAX : dvd[TimeW-1:0];

  // restoring division, quotient bits shifted in behind the dividend
  always_comb begin
    dvd_next = dvd;
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < DivBitsPerStep; i++) begin
      trial = {rem_next, dvd_next[WsumW-1]};
      if (trial >= {1'b0, dsr}) begin
        trial = trial - {1'b0, dsr};
        dvd_next = {dvd_next[WsumW-2:0], 1'b1};
      end else begin
        dvd_next = {dvd_next[WsumW-2:0], 1'b0};
      end
      rem_next = trial[TpqW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tpq  <= TPQ_RESET;
      wsum <= '0;
      cnt  <= '0;
    end else begin
      if (tpq_wr) tpq <= tpq_wdata;
      if (cmd.clr) begin
        wsum <= '0;
      end else if (cmd.acc) begin
        wsum <= wsum_add[WsumW] ? {WsumW{1'b1}} : wsum_add[WsumW-1:0];
      end
      if (cmd.div_load) begin
        cnt <= '0;
      end else if (cmd.div_run) begin
        cnt <= cnt + DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= delta_hold * tempo_now;
    if (cmd.div_load) begin
      dvd <= wsum;
      rem <= '0;
    end else if (cmd.div_run) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

endmodule
`default_nettype wire

/* tb/midi_track_event_parser_checker.sv */
// Checker for the MIDI track event parser: predicts event items and compares them.
`timescale 1ns / 100ps
module midi_track_event_parser_checker
  import mtp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  mtp_in_if.sink     in_mon,
  mtp_out_if.sink    out_mon,
  mtp_cfg_if.sink    cfg_mon,
  output int         fail_count,
  output int         pending,
  output int         event_count
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic        has_second;
    logic [31:0] tick_total;
    logic [47:0] time_us;
  } event_t;

  event_t event_q[$];

  logic [15:0] tpq;
  logic [23:0] tempo_init;
  ph_t         ph;
  logic [2:0]  cnt;
  logic [31:0] vacc;
  logic [31:0] skip_n;
  logic [7:0]  run_type;
  logic [7:0]  held;
  logic [23:0] tempo;
  logic [15:0] tempo_acc;
  logic [31:0] ticks;
  logic [63:0] wsum;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic event_t stamp(input logic [1:0] k, input logic [7:0] st,
                                   input logic [7:0] d0, input logic [7:0] d1,
                                   input logic two, input logic stamped);
    event_t e;
    logic [63:0] t;
    t = wsum / ((tpq == 0) ? 64'd1 : {48'd0, tpq});
    if (t > {16'd0, TIME_MAX}) t = {16'd0, TIME_MAX};
    e.kind = k;
    e.status_byte = st;
    e.first_data = d0;
    e.second_data = d1;
    e.has_second = two;
    e.tick_total = stamped ? ticks : 32'd0;
    e.time_us = stamped ? t[47:0] : 48'd0;
    return e;
  endfunction

  function automatic logic meta_branch(input logic [7:0] t);
    return t < 8'h80 || t == ST_SYSEX || t == ST_SYSEX_CT;
  endfunction

  task automatic chan_first(input logic [7:0] d0);
    if ((run_type & MASK_CLASS) != CLASS_1DATA) begin
      held = d0;
      ph = PH_DATA2;
    end else begin
      event_q.push_back(stamp(KIND_CHAN, run_type, d0, 8'd0, 1'b0, 1'b1));
      vacc = 0;
      ph = PH_DELTA;
    end
  endtask

  task automatic route(input logic [7:0] d0);
    if (meta_branch(run_type)) begin
      vacc = 0;
      ph = PH_LEN;
    end else begin
      chan_first(d0);
    end
  endtask

  task automatic parse_byte(input logic c, input logic [7:0] b);
    logic [63:0] prod;
    logic [32:0] tsum;
    logic [64:0] wnew;
    if (c) begin
      ph = PH_TAG; cnt = 0; vacc = 0; skip_n = 0; run_type = 0; held = 0;
      tempo_acc = 0; ticks = 0; wsum = 0;
    end else begin
      case (ph)
        PH_TAG, PH_TAGBAD: begin
          if (b != tag_byte(cnt[1:0])) ph = PH_TAGBAD;
          cnt++;
          if (cnt >= 4) begin
            cnt = 0;
            if (ph == PH_TAGBAD) begin
              ph = PH_IDLE;
              event_q.push_back(stamp(KIND_BADTAG, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
            end else begin
              ph = PH_LENSKIP;
            end
          end
        end
        PH_LENSKIP: begin
          cnt++;
          if (cnt >= 4) begin
            cnt = 0; vacc = 0; ph = PH_DELTA;
          end
        end
        PH_DELTA: begin
          vacc = {vacc[24:0], b[6:0]};
          if (!b[7]) begin
            prod = {32'd0, vacc} * {40'd0, tempo};
            tsum = {1'b0, ticks} + {1'b0, vacc};
            ticks = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
            wnew = {1'b0, wsum} + {1'b0, prod};
            wsum = wnew[64] ? 64'hFFFF_FFFF_FFFF_FFFF : wnew[63:0];
            vacc = 0;
            ph = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b[7]) begin
            if (b == ST_META) begin
              ph = PH_METATYP;
            end else begin
              run_type = b;
              if (b == ST_SYSEX || b == ST_SYSEX_CT) begin
                vacc = 0; ph = PH_LEN;
              end else begin
                ph = PH_DATA1;
              end
            end
          end else begin
            route(b);
          end
        end
        PH_METATYP: begin
          run_type = b;
          route(ST_META);
        end
        PH_DATA1: chan_first(b);
        PH_DATA2: begin
          event_q.push_back(stamp(KIND_CHAN, run_type, held, b, 1'b1, 1'b1));
          vacc = 0; ph = PH_DELTA;
        end
        PH_LEN: begin
          vacc = {vacc[24:0], b[6:0]};
          if (!b[7]) begin
            if (run_type == META_EOT) begin
              vacc = 0; ph = PH_IDLE;
              event_q.push_back(stamp(KIND_EOT, META_EOT, 8'd0, 8'd0, 1'b0, 1'b1));
            end else begin
              if (run_type == META_TEMPO) begin
                cnt = 0; tempo_acc = 0; ph = PH_TEMPO;
              end else begin
                skip_n = (run_type == META_TIMSIG) ? 32'd4 : vacc;
                ph = (skip_n != 0) ? PH_SKIP : PH_DELTA;
              end
              vacc = 0;
            end
          end
        end
        PH_SKIP: begin
          if (skip_n != 0) skip_n--;
          if (skip_n == 0) begin
            vacc = 0; ph = PH_DELTA;
          end
        end
        PH_TEMPO: begin
          if (cnt < 2) begin
            tempo_acc = {tempo_acc[7:0], b};
            cnt++;
          end else begin
            tempo = {tempo_acc, b};
            cnt = 0; vacc = 0; ph = PH_DELTA;
          end
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    event_t got, want;
    if (rst) begin
      tpq = TPQ_RESET; tempo_init = TEMPO_RESET; ph = PH_IDLE; cnt = 0; vacc = 0;
      skip_n = 0; run_type = 0; held = 0; tempo = TEMPO_RESET; tempo_acc = 0;
      ticks = 0; wsum = 0;
      event_q.delete();
      fail_count = 0;
      event_count = 0;
      pending = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_TPQ) begin
          tpq = cfg_mon.data[15:0];
        end else begin
          tempo_init = cfg_mon.data;
          tempo = cfg_mon.data;
        end
      end
      if (in_mon.valid && in_mon.ready) parse_byte(in_mon.cmd, in_mon.byte_in);
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.kind, out_mon.status_byte, out_mon.first_data, out_mon.second_data,
                out_mon.has_second, out_mon.tick_total, out_mon.time_us};
        event_count++;
        if (event_q.size() == 0) begin
          $display("%0t: event item with none expected", $realtime);
          fail_count++;
        end else begin
          want = event_q.pop_front();
          if (got.kind != want.kind) report("kind", got.kind, want.kind);
          if (got.status_byte != want.status_byte)
            report("status_byte", got.status_byte, want.status_byte);
          if (got.first_data != want.first_data)
            report("first_data", got.first_data, want.first_data);
          if (got.second_data != want.second_data)
            report("second_data", got.second_data, want.second_data);
          if (got.has_second != want.has_second)
            report("has_second", got.has_second, want.has_second);
          if (got.tick_total != want.tick_total)
            report("tick_total", got.tick_total, want.tick_total);
          if (got.time_us != want.time_us) report("time_us", got.time_us, want.time_us);
        end
      end
      pending = event_q.size();
    end
  end

endmodule

/* tb/midi_track_event_parser_test.sv */
// Top of the MIDI track event parser testbench: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module midi_track_event_parser_test;
  import mtp_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   event_count;
  int   bytes_sent;
  bit   sink_busy;

  mtp_in_if  in_ch();
  mtp_out_if out_ch();
  mtp_cfg_if cfg_ch();

  midi_track_event_parser DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  midi_track_event_parser_checker checker_i (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending(pending), .event_count(event_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Timeout with %0d event items outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: once sink_busy is set, stall at random, now and then for long stretches.
  initial begin
    int g;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (1) begin
      g = sink_busy ? gap_len() : 0;
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic put(input logic c, input logic [7:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= c;
    in_ch.byte_in <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic open_track();
    put(1'b1, $urandom_range(0, 255));
    put(1'b0, TAG_M); put(1'b0, TAG_T); put(1'b0, TAG_R); put(1'b0, TAG_K);
    repeat (4) put(1'b0, $urandom_range(0, 255));
  endtask

  task automatic send_varlen(input logic [31:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--)
      put(1'b0, {(i != 0), 7'((v >> (7 * i)) & 32'h7F)});
  endtask

  task automatic send_delta();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) send_varlen($urandom_range(0, 127), 1);
    else if (r < 9) send_varlen($urandom_range(0, 16383), 2);
    else send_varlen($urandom(), 5);
  endtask

  // Let the last accepted item reach the checker before looking at what is open.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [23:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // One random event after a delta; mostly well-formed, some broken.
  task automatic send_event();
    int r;
    logic [7:0] st;
    int n;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom())};
      put(1'b0, st);
      put(1'b0, $urandom_range(0, 127));
      if ((st & MASK_CLASS) != CLASS_1DATA) put(1'b0, $urandom_range(0, 127));
    end else if (r < 60) begin
      put(1'b0, $urandom_range(0, 127));
      put(1'b0, $urandom_range(0, 127));
    end else if (r < 68) begin
      put(1'b0, ST_META); put(1'b0, META_TEMPO); put(1'b0, 8'h03);
      repeat (3) put(1'b0, $urandom_range(0, 255));
    end else if (r < 73) begin
      put(1'b0, ST_META); put(1'b0, META_TIMSIG); put(1'b0, $urandom_range(0, 127));
      repeat (4) put(1'b0, $urandom_range(0, 255));
    end else if (r < 83) begin
      put(1'b0, ($urandom_range(0, 1) != 0) ? ST_SYSEX : ST_SYSEX_CT);
      n = $urandom_range(0, 6);
      send_varlen(n, 1);
      repeat (n) put(1'b0, $urandom_range(0, 255));
    end else if (r < 90) begin
      put(1'b0, ST_META); put(1'b0, $urandom_range(0, 127));
      n = $urandom_range(0, 5);
      send_varlen(n, 1);
      repeat (n) put(1'b0, $urandom_range(0, 255));
    end else if (r < 94) begin
      put(1'b0, ST_META); put(1'b0, $urandom_range(8'h80, 8'hFF));
      put(1'b0, $urandom_range(0, 255));
    end else begin
      put(1'b0, $urandom_range(0, 255));
    end
  endtask

  initial begin
    rst = 1'b1;
    sink_busy = 1'b0;
    bytes_sent = 0;
    in_ch.valid <= 1'b0; in_ch.cmd <= 1'b0; in_ch.byte_in <= 8'd0;
    cfg_ch.valid <= 1'b0; cfg_ch.index <= REG_TPQ; cfg_ch.data <= 24'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle data, bad tag, extremes, tempo, end of track.
    put(1'b0, 8'hFF);
    put(1'b1, 8'h00);
    put(1'b0, TAG_M); put(1'b0, 8'h00); put(1'b0, TAG_R); put(1'b0, TAG_K);
    put(1'b0, 8'h00);
    open_track();
    put(1'b0, 8'h00); put(1'b0, 8'h90); put(1'b0, 8'h00); put(1'b0, 8'hFF);
    send_varlen(32'hFFFF_FFFF, 5); put(1'b0, 8'hC5); put(1'b0, 8'h7F);
    put(1'b0, 8'h7F); put(1'b0, 8'hFF); put(1'b0, META_TEMPO); put(1'b0, 8'h00);
    put(1'b0, 8'hFF); put(1'b0, 8'hFF); put(1'b0, 8'hFF);
    put(1'b0, 8'h81); put(1'b0, 8'h00); put(1'b0, 8'hF1); put(1'b0, 8'h12);
    put(1'b0, 8'h34);
    put(1'b0, 8'h00); put(1'b0, ST_META); put(1'b0, META_EOT); put(1'b0, 8'h00);
    quiesce();

    sink_busy = 1'b1;
    for (int phase_i = 0; phase_i < 5; phase_i++) begin
      case (phase_i)
        0: begin write_reg(REG_TPQ, 24'd0); write_reg(REG_TEMPO, 24'hFFFFFF); end
        1: begin write_reg(REG_TPQ, 24'd1); write_reg(REG_TEMPO, 24'd1); end
        2: begin write_reg(REG_TPQ, 24'hFFFF); write_reg(REG_TEMPO, 24'd500000); end
        3: begin write_reg(REG_TPQ, 24'd96); write_reg(REG_TEMPO, $urandom_range(1, 24'hFFFFFF)); end
        default: begin
          write_reg(REG_TPQ, $urandom_range(1, 16'hFFFF));
          write_reg(REG_TEMPO, $urandom_range(1, 24'hFFFFFF));
        end
      endcase
      repeat (4) begin
        open_track();
        repeat ($urandom_range(5, 25)) begin
          send_delta();
          send_event();
        end
        if ($urandom_range(0, 3) != 0) begin
          send_delta(); put(1'b0, ST_META); put(1'b0, META_EOT); put(1'b0, 8'h00);
        end
      end
      quiesce();
    end

    $display("Sent %0d bytes over five register settings; %0d event items checked",
             bytes_sent, event_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
